### src/lkvt_pkg.sv
// lkvt_pkg: shared types, codes and field widths of the linear key/value table
// no dependencies; used by every module of the table except lkvt_ram

package lkvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // request action codes as seen on the port
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_GET    = 2'd2;

   // internal operation codes after classification
   localparam logic [1:0] OP_NOP    = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_GET    = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // classified request as it waits in the queue
   typedef struct packed {
      logic [1:0]         op;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

### src/lkvt_ram.sv
// lkvt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module lkvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lkvt_front.sv
// lkvt_front: request acceptance and classification into queue commands
// depends on lkvt_pkg

module lkvt_front (
   input  logic              start,
   output logic              busy,
   input  lkvt_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output lkvt_pkg::cmd_type cmd
);

   assign busy = queue_full;
   assign push = start && !queue_full;

   always_comb begin
      cmd.key   = req_data.key;
      cmd.value = '0;
      unique case (req_data.action)
         lkvt_pkg::ACT_ADD: begin
            cmd.op    = lkvt_pkg::OP_ADD;
            cmd.value = req_data.value;
         end
         lkvt_pkg::ACT_REMOVE: cmd.op = lkvt_pkg::OP_REMOVE;
         lkvt_pkg::ACT_GET:    cmd.op = lkvt_pkg::OP_GET;
         default:              cmd.op = lkvt_pkg::OP_NOP;
      endcase
   end

endmodule

### src/lkvt_queue.sv
// lkvt_queue: two-entry command queue between the front and the back end
// depends on lkvt_pkg

module lkvt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lkvt_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output lkvt_pkg::cmd_type head_cmd
);

   lkvt_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/lkvt_back.sv
// lkvt_back: executes queued commands against the entry ram, one entry per cycle
// depends on lkvt_pkg and lkvt_ram

module lkvt_back #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  lkvt_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   output lkvt_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = lkvt_pkg::KEY_W + lkvt_pkg::VALUE_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [1:0]                  op_ff, op_in;
   logic [lkvt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lkvt_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [DATA_W-1:0]           wr_data;
   logic [IDX_W-1:0]            rd_addr;
   logic [DATA_W-1:0]           rd_data;
   logic                        last;
   logic                        hit;

   lkvt_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // rd_data always holds the entry at idx_ff while scanning or shifting
   assign last = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
   assign hit  = (rd_data[DATA_W-1:lkvt_pkg::VALUE_W] == key_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = idx_ff + IDX_W'(1);
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (q_not_empty) begin
               q_pop                 = 1'b1;
               op_in                 = q_cmd.op;
               key_in                = q_cmd.key;
               idx_in                = '0;
               rsp_data_in.value_out = '0;
               unique case (q_cmd.op) inside
                  lkvt_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_data_in.status      = lkvt_pkg::ST_FULL;
                        rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_ff);
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = {q_cmd.key, q_cmd.value};
                        count_in = count_ff + CNT_W'(1);
                        rsp_data_in.status      = lkvt_pkg::ST_OK;
                        rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_in);
                     end
                  end
                  lkvt_pkg::OP_REMOVE, lkvt_pkg::OP_GET: begin
                     if (count_ff == '0) begin
                        rsp_valid_in            = 1'b1;
                        rsp_data_in.status      = lkvt_pkg::ST_MISS;
                        rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_ff);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.status      = lkvt_pkg::ST_OK;
                     rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_ff);
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               if (op_ff == lkvt_pkg::OP_GET) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = lkvt_pkg::ST_OK;
                  rsp_data_in.value_out   = rd_data[lkvt_pkg::VALUE_W-1:0];
                  rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_ff);
                  state_in                = S_IDLE;
               end else if (last) begin
                  count_in                = count_ff - CNT_W'(1);
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = lkvt_pkg::ST_OK;
                  rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_in);
                  state_in                = S_IDLE;
               end else begin
                  // the read of the next entry is already under way
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_SHIFT;
               end
            end else if (last) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = lkvt_pkg::ST_MISS;
               rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_ff);
               state_in                = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT: begin
            // move the entry at idx down one place
            wr_en   = 1'b1;
            wr_addr = idx_ff - IDX_W'(1);
            wr_data = rd_data;
            if (last) begin
               count_in                = count_ff - CNT_W'(1);
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = lkvt_pkg::ST_OK;
               rsp_data_in.entry_count = lkvt_pkg::COUNT_W'(count_in);
               state_in                = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      key_ff      <= key_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/linear_key_value_table_unit.sv
// linear_key_value_table_unit: top level of the linear key/value table
// adds and unused action codes need no walk of the entry ram; a lookup that hits entry i
// stops there, while removes and misses on a non-empty table walk to the last entry
// throughput: one add per cycle unless a walk runs; walks take one entry a cycle
// reset empties the table at once; a two-deep queue lets requests arrive while one runs
// results are registered and shown for one cycle; the receiver cannot stall them

module linear_key_value_table_unit #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lkvt_pkg::req_type req_data,
   output logic              rsp_valid,
   output lkvt_pkg::rsp_type rsp_data
);

   logic              push;
   logic              queue_full;
   logic              q_not_empty;
   logic              q_pop;
   lkvt_pkg::cmd_type push_cmd;
   lkvt_pkg::cmd_type head_cmd;

   lkvt_front u_front (
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .queue_full(queue_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   lkvt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .head_cmd (head_cmd)
   );

   lkvt_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
